FILE: hdl/hsd_pkg.sv
// Shared constants, types and state codes for the Huffman stream decoder.
`default_nettype none
package hsd_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int INNER_COUNT  = SYMBOL_COUNT - 1;
  localparam int NODE_LIMIT   = 2 * SYMBOL_COUNT - 1;
  localparam int NODE_W       = $clog2(NODE_LIMIT + 1);
  localparam int IDX_W        = $clog2(INNER_COUNT);
  localparam int HDR_W        = 10;
  localparam int CNT_W        = 4;

  localparam logic [HDR_W-1:0] HDR_PAD    = HDR_W'(0);
  localparam logic [HDR_W-1:0] HDR_ROOT   = HDR_W'(1);
  localparam logic [HDR_W-1:0] HDR_FIRST  = HDR_W'(2);
  localparam logic [HDR_W-1:0] DATA_PHASE = HDR_W'(2 + NODE_LIMIT);

  localparam logic [7:0] NO_PARENT = 8'd127;
  localparam logic [7:0] CODE_FLIP = 8'h80;
  localparam logic [7:0] PAD_MAX   = 8'd7;
  localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);
  localparam logic [NODE_W-1:0] NODE_TOP = NODE_W'(NODE_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Child lookup for the current walk node and bit.
  typedef struct packed {
    logic              present;  // selected child exists
    logic [NODE_W-1:0] child;    // selected child node
    logic              is_leaf;  // child has no children of its own
  } child_rsp_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       err;
  } sym_t;

endpackage
`default_nettype wire

FILE: hdl/hsd_child_tbl.sv
// Left/right child memories with per-entry left-valid bits and leaf check.
`default_nettype none
module hsd_child_tbl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clr,
  input  wire logic                      wr_en,
  input  wire logic [hsd_pkg::IDX_W-1:0]  wr_idx,
  input  wire logic [hsd_pkg::NODE_W-1:0] wr_node,
  input  wire logic [hsd_pkg::IDX_W-1:0]  rd_idx,
  input  wire logic [hsd_pkg::NODE_W-1:0] qry_node,
  input  wire logic                      qry_bit,
  output hsd_pkg::child_rsp_t            rsp
);

  logic [hsd_pkg::NODE_W-1:0] left_mem  [hsd_pkg::INNER_COUNT];
  logic [hsd_pkg::NODE_W-1:0] right_mem [hsd_pkg::INNER_COUNT];
  logic [hsd_pkg::INNER_COUNT-1:0] lv_r;
  logic [hsd_pkg::NODE_W-1:0] lrd_r, rrd_r;

  logic                      qry_in_rng;
  logic [hsd_pkg::IDX_W-1:0] qry_idx;
  logic [hsd_pkg::IDX_W-1:0] chd_idx;

  // a node has children exactly when its left side is filled
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      lv_r <= '0;
    end else if (wr_en && !lv_r[wr_idx]) begin
      lv_r[wr_idx] <= 1'b1;
    end
  end

  // first child seen goes left, later ones overwrite right;
  // node 511 is never a child, so it marks an empty right side
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (!lv_r[wr_idx]) begin
        left_mem[wr_idx]  <= wr_node;
        right_mem[wr_idx] <= hsd_pkg::NODE_TOP;
      end else begin
        right_mem[wr_idx] <= wr_node;
      end
    end
    lrd_r <= left_mem[rd_idx];
    rrd_r <= right_mem[rd_idx];
  end

  always_comb begin
    qry_idx     = qry_node[hsd_pkg::IDX_W-1:0];
    qry_in_rng  = qry_node[hsd_pkg::NODE_W-1] && (qry_node != hsd_pkg::NODE_TOP);
    rsp.present = qry_in_rng && lv_r[qry_idx] && (!qry_bit || (rrd_r != hsd_pkg::NODE_TOP));
    rsp.child   = qry_bit ? rrd_r : lrd_r;
    chd_idx     = rsp.child[hsd_pkg::IDX_W-1:0];
    rsp.is_leaf = !rsp.child[hsd_pkg::NODE_W-1] || !lv_r[chd_idx];
  end

endmodule
`default_nettype wire

FILE: hdl/hsd_out_stage.sv
// Pending-symbol hold and output register; marks the last symbol of a byte.
`default_nettype none
module hsd_out_stage (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        leaf_en,
  input  wire hsd_pkg::sym_t leaf,
  input  wire logic        fin_en,
  input  wire logic        out_stall,
  output logic             blocked,
  output logic             out_valid,
  output logic [7:0]       out_symbol,
  output logic             out_run_last,
  output logic             out_walk_error
);

  hsd_pkg::sym_t pend_r;
  logic          pend_v_r;
  logic          out_v_r;
  hsd_pkg::sym_t out_r;
  logic          out_last_r;
  logic          out_free;
  logic          push;

  assign out_free = !out_v_r || !out_stall;
  assign blocked  = pend_v_r && !out_free;
  assign push     = pend_v_r && (leaf_en || fin_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (leaf_en)     pend_v_r <= 1'b1;
      else if (fin_en) pend_v_r <= 1'b0;
      if (push)           out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leaf_en) pend_r <= leaf;
    if (push) begin
      out_r      <= pend_r;
      out_last_r <= fin_en;
    end
  end

  assign out_valid      = out_v_r;
  assign out_symbol     = out_r.symbol;
  assign out_walk_error = out_r.err;
  assign out_run_last   = out_last_r;

endmodule
`default_nettype wire

FILE: hdl/huffman_stream_decoder_top.sv
// Top level of the static Huffman stream decoder: header parsing and tree walk sequencer.
`default_nettype none
// Decodes one compressed file per run of input transactions. The first byte is the
// pad count of the final byte, the second the root code, the next 511 the parent
// codes of nodes 0..510; every later byte is code bits, walked MSB first. Header
// bytes are taken without a stall. A data byte is accepted, then its bits are
// walked one by one (8, or 8 minus pad on the final byte), then the byte's last
// symbol is handed off; the child table is read once per bit, with the next
// node's children registered for the following bit. Output stalls stretch the
// walk. The input is stalled while a byte is being walked. Each decoded symbol
// is one output transaction; run_last marks the final symbol of its input byte,
// walk_error reports any malformed pad count or walk seen so far in the file.
// After the transaction that carries is_last, all tree state is cleared at once
// (valid bits, no sweep).
module huffman_stream_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_symbol,
  output logic            out_run_last,
  output logic            out_walk_error
);

  hsd_pkg::state_t state_r, state_nxt;
  logic [hsd_pkg::HDR_W-1:0]  hp_r, hp_nxt;
  logic [2:0]                 pad_r, pad_nxt;
  logic [hsd_pkg::NODE_W-1:0] root_r, root_nxt;
  logic [hsd_pkg::NODE_W-1:0] walk_r, walk_nxt;
  logic                       err_r, err_nxt;
  logic [7:0]                 sh_r, sh_nxt;
  logic [hsd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       last_r, last_nxt;

  logic                      do_clr;
  logic                      wr_en;
  logic [hsd_pkg::HDR_W-1:0] node_full;
  hsd_pkg::child_rsp_t       rsp;
  logic                      leaf_en, fin_en, blocked;
  hsd_pkg::sym_t             leaf;
  logic                      is_leaf;

  assign in_stall  = (state_r != hsd_pkg::ST_IDLE);
  assign node_full = hp_r - hsd_pkg::HDR_FIRST;
  assign is_leaf   = rsp.present && rsp.is_leaf;
  assign leaf.symbol = rsp.child[7:0] ^ hsd_pkg::CODE_FLIP;
  assign leaf.err    = err_r;

  always_comb begin
    state_nxt = state_r;
    hp_nxt    = hp_r;
    pad_nxt   = pad_r;
    root_nxt  = root_r;
    walk_nxt  = walk_r;
    err_nxt   = err_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    do_clr    = 1'b0;
    wr_en     = 1'b0;
    leaf_en   = 1'b0;
    fin_en    = 1'b0;

    unique case (state_r)
      hsd_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (hp_r == hsd_pkg::HDR_PAD) begin
            // oversize pad count saturates and flags the file
            if (in_byte > hsd_pkg::PAD_MAX) begin
              pad_nxt = 3'd7;
              err_nxt = 1'b1;
            end else begin
              pad_nxt = in_byte[2:0];
            end
            hp_nxt = hsd_pkg::HDR_ROOT;
          end else if (hp_r == hsd_pkg::HDR_ROOT) begin
            root_nxt = {1'b1, in_byte ^ hsd_pkg::CODE_FLIP};
            walk_nxt = {1'b1, in_byte ^ hsd_pkg::CODE_FLIP};
            hp_nxt   = hsd_pkg::HDR_FIRST;
          end else if (hp_r != hsd_pkg::DATA_PHASE) begin
            wr_en  = (in_byte != hsd_pkg::NO_PARENT);
            hp_nxt = hp_r + hsd_pkg::HDR_W'(1);
          end else begin
            sh_nxt    = in_byte;
            last_nxt  = in_is_last;
            cnt_nxt   = in_is_last ? hsd_pkg::BYTE_BITS - {1'b0, pad_r}
                                   : hsd_pkg::BYTE_BITS;
            state_nxt = hsd_pkg::ST_WALK;
          end
          // early end inside the header: nothing to emit
          if (in_is_last && hp_r != hsd_pkg::DATA_PHASE) do_clr = 1'b1;
        end
      end
      hsd_pkg::ST_WALK: begin
        // one code bit per cycle; hold only when a symbol can't be parked
        if (!(is_leaf && blocked)) begin
          if (!rsp.present) begin
            err_nxt  = 1'b1;
            walk_nxt = root_r;
          end else if (rsp.is_leaf) begin
            leaf_en  = 1'b1;
            walk_nxt = root_r;
          end else begin
            walk_nxt = rsp.child;
          end
          sh_nxt  = {sh_r[6:0], 1'b0};
          cnt_nxt = cnt_r - hsd_pkg::CNT_W'(1);
          if (cnt_r == hsd_pkg::CNT_W'(1)) state_nxt = hsd_pkg::ST_FLUSH;
        end
      end
      hsd_pkg::ST_FLUSH: begin
        if (!blocked) begin
          fin_en    = 1'b1;
          state_nxt = hsd_pkg::ST_IDLE;
          do_clr    = last_r;
        end
      end
      default: state_nxt = hsd_pkg::ST_IDLE;
    endcase

    if (do_clr) begin
      hp_nxt   = hsd_pkg::HDR_PAD;
      pad_nxt  = '0;
      root_nxt = '0;
      walk_nxt = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsd_pkg::ST_IDLE;
      hp_r    <= hsd_pkg::HDR_PAD;
      pad_r   <= '0;
      root_r  <= '0;
      walk_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hp_r    <= hp_nxt;
      pad_r   <= pad_nxt;
      root_r  <= root_nxt;
      walk_r  <= walk_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  // read address follows the next walk node so its children are ready next cycle
  hsd_child_tbl u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (do_clr),
    .wr_en    (wr_en),
    .wr_idx   (in_byte ^ hsd_pkg::CODE_FLIP),
    .wr_node  (node_full[hsd_pkg::NODE_W-1:0]),
    .rd_idx   (walk_nxt[hsd_pkg::IDX_W-1:0]),
    .qry_node (walk_r),
    .qry_bit  (sh_r[7]),
    .rsp      (rsp)
  );

  hsd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .leaf_en        (leaf_en),
    .leaf           (leaf),
    .fin_en         (fin_en),
    .out_stall      (out_stall),
    .blocked        (blocked),
    .out_valid      (out_valid),
    .out_symbol     (out_symbol),
    .out_run_last   (out_run_last),
    .out_walk_error (out_walk_error)
  );

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the Huffman stream decoder: tree headers, code walks, handshakes.
module tb;

  localparam logic [9:0] KID_NONE    = 10'h3FF;  // no child stored for this side
  localparam int         QUIET_LIMIT = 5000;     // cycles with no transaction before giving up
  localparam int         HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int         PLAN_LEN    = 20;

  // One decoded symbol as it should appear on the result channel.
  typedef struct packed {
    logic [7:0] symbol;
    logic       run_last;
    logic       walk_error;
  } sym_rec_t;

  // Directed rows: a header row sends a complete 513-byte header built from a
  // known tree (pad byte in b, root code in root); a byte row sends one byte.
  typedef enum logic [1:0] {
    ROW_HEAP,    // complete depth-8 tree: every data byte decodes to byte ^ 0x80
    ROW_SPARSE,  // leaf 0 and node 257 under root 256, node 258 under 257
    ROW_BYTE
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] b;
    logic [7:0] root;
    logic       last;
    logic       known;  // exactly one result, given by sym and err
    logic [7:0] sym;
    logic       err;
  } row_t;

  localparam row_t PLAN [PLAN_LEN] = '{
    // file ends on its pad byte
    '{ROW_BYTE,   8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    // oversized pad, root 511, file ends on the root byte
    '{ROW_BYTE,   8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h7F, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    // full tree rooted at 256, pad 0
    '{ROW_HEAP,   8'h00, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h00, 8'h00, 1'b0, 1'b1, 8'h80, 1'b0},
    '{ROW_BYTE,   8'hFF, 8'h00, 1'b0, 1'b1, 8'h7F, 1'b0},
    '{ROW_BYTE,   8'h5A, 8'h00, 1'b0, 1'b1, 8'hDA, 1'b0},
    '{ROW_BYTE,   8'h80, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
    // pad 255 saturates and flags; root 384 has leaves 2 and 3 below it
    '{ROW_HEAP,   8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'hA5, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h80, 8'h00, 1'b1, 1'b1, 8'h83, 1'b1},
    // sparse tree, pad 3: childless node, unset child, late error
    '{ROW_SPARSE, 8'h03, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h80, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h03, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'hC0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    // root 511 has no children: every bit is an error, nothing decodes
    '{ROW_HEAP,   8'h04, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE,   8'h0F, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_is_last;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_symbol;
  logic       out_run_last;
  logic       out_walk_error;

  huffman_stream_decoder_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .out_run_last   (out_run_last),
    .out_walk_error (out_walk_error)
  );

  // Decoder mirror: header position, pad, root, walk position, child tables.
  logic [hsd_pkg::HDR_W-1:0] hdr_pos;
  logic [2:0]       pad_cnt;
  logic [9:0]       root_id;
  logic [9:0]       cur_id;
  logic [9:0]       kid_l [hsd_pkg::INNER_COUNT];
  logic [9:0]       kid_r [hsd_pkg::INNER_COUNT];
  logic             err_flag;

  sym_rec_t   fresh[$];            // symbols caused by the byte just accepted
  sym_rec_t   pending_symbols[$];  // symbols still owed by the DUT
  logic [7:0] hdr_buf [0:hsd_pkg::NODE_LIMIT+1];

  int   err_count = 0;
  int   quiet = 0;
  int   hold_left = 0;
  logic hold_used = 1'b0;
  logic hold_req;   // sender asks for the long receiver hold-off
  logic calm;       // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Header code byte for a node: signed value plus 384.
  function automatic logic [7:0] node_code(input int n);
    return (n >= 384) ? 8'(n - 384) : 8'(n - 128);
  endfunction

  function automatic logic [9:0] code_node(input logic [7:0] b);
    return b[7] ? {2'b00, b} + 10'd128 : {2'b00, b} + 10'd384;
  endfunction

  // Only nodes 256..510 can hold children.
  function automatic logic [9:0] kid_of(input logic [9:0] node, input logic dir);
    if (node < hsd_pkg::SYMBOL_COUNT || node >= hsd_pkg::NODE_LIMIT) return KID_NONE;
    return dir ? kid_r[node - hsd_pkg::SYMBOL_COUNT] : kid_l[node - hsd_pkg::SYMBOL_COUNT];
  endfunction

  function automatic void clear_tree();
    int k;
    hdr_pos  = hsd_pkg::HDR_PAD;
    pad_cnt  = 3'd0;
    root_id  = 10'd0;
    cur_id   = 10'd0;
    err_flag = 1'b0;
    for (k = 0; k < hsd_pkg::INNER_COUNT; k++) begin
      kid_l[k] = KID_NONE;
      kid_r[k] = KID_NONE;
    end
  endfunction

  // Advance the mirror by one accepted byte; decoded symbols land in fresh.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    int         idx;
    int         i;
    int         nbits;
    logic [9:0] c;
    fresh.delete();
    if (hdr_pos == hsd_pkg::HDR_PAD) begin
      if (b > hsd_pkg::PAD_MAX) begin
        pad_cnt  = 3'd7;
        err_flag = 1'b1;
      end else begin
        pad_cnt = b[2:0];
      end
      hdr_pos = hsd_pkg::HDR_ROOT;
    end else if (hdr_pos == hsd_pkg::HDR_ROOT) begin
      root_id = code_node(b);
      cur_id  = root_id;
      hdr_pos = hsd_pkg::HDR_FIRST;
    end else if (hdr_pos < hsd_pkg::DATA_PHASE) begin
      if (b != hsd_pkg::NO_PARENT) begin
        idx = int'(code_node(b)) - hsd_pkg::SYMBOL_COUNT;
        if (idx < hsd_pkg::INNER_COUNT) begin
          // first child seen goes left, any later one overwrites right
          if (kid_l[idx] == KID_NONE) kid_l[idx] = 10'(hdr_pos - hsd_pkg::HDR_FIRST);
          else kid_r[idx] = 10'(hdr_pos - hsd_pkg::HDR_FIRST);
        end
      end
      hdr_pos = hdr_pos + 1'b1;
    end else begin
      nbits = last ? 8 - int'(pad_cnt) : 8;
      for (i = 0; i < nbits; i++) begin
        c = kid_of(cur_id, b[7-i]);
        if (c == KID_NONE) begin
          err_flag = 1'b1;
          cur_id   = root_id;
        end else if (kid_of(c, 1'b0) == KID_NONE && kid_of(c, 1'b1) == KID_NONE) begin
          fresh.push_back('{symbol: c[7:0] ^ hsd_pkg::CODE_FLIP, run_last: 1'b0,
                            walk_error: err_flag});
          cur_id = root_id;
        end else begin
          cur_id = c;
        end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].run_last = 1'b1;
    end
    if (last) clear_tree();
  endfunction

  // Complete depth-8 tree in heap order: node 255+h has children 2h, 2h+1,
  // heap indexes of 256 and up being leaves. Even heap slots come first, so
  // they end up as left children and a byte walks straight to leaf = byte.
  function automatic void fill_heap(input logic [7:0] pad, input logic [7:0] root_byte);
    int n;
    hdr_buf[0] = pad;
    hdr_buf[1] = root_byte;
    for (n = 0; n < hsd_pkg::NODE_LIMIT; n++) begin
      if (n < hsd_pkg::SYMBOL_COUNT) hdr_buf[2+n] = node_code(255 + (256 + n) / 2);
      else if (n == hsd_pkg::SYMBOL_COUNT) hdr_buf[2+n] = hsd_pkg::NO_PARENT;
      else hdr_buf[2+n] = node_code(255 + (n - 255) / 2);
    end
  endfunction

  // Offer one byte, with random idle cycles ahead of it, and wait for the
  // transaction. The stall seen right after the edge is the one the DUT saw.
  task automatic put_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_byte(b, last);
    foreach (fresh[k]) pending_symbols.push_back(fresh[k]);
  endtask

  task automatic send_header();
    int i;
    for (i = 0; i < hsd_pkg::DATA_PHASE; i++) put_byte(hdr_buf[i], 1'b0);
  endtask

  // Sender goes quiet until the DUT has delivered everything owed.
  task automatic settle_symbols();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_symbols.size() != 0) @(posedge clk);
  endtask

  // Result side: check each transaction against the oldest owed symbol, then
  // pick the stall for the next cycle (random, long hold-off, or none when calm).
  always @(posedge clk) begin
    sym_rec_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        $error("unexpected transaction: symbol %0d run_last %0d walk_error %0d",
               out_symbol, out_run_last, out_walk_error);
        err_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (out_symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, out_symbol);
          err_count++;
        end
        if (out_run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, out_run_last);
          err_count++;
        end
        if (out_walk_error !== want.walk_error) begin
          $error("walk_error: expected %0d, got %0d", want.walk_error, out_walk_error);
          err_count++;
        end
      end
    end
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 10);
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int         r;
    int         i;
    int         k;
    int         j;
    int         a;
    int         b;
    int         p;
    int         file_no;
    int         pick;
    int         leaves;
    int         cut;
    int         n_data;
    int         d;
    int         data_sent;
    int         symbols_seen;
    int         leaf_ids[$];
    int         inner_ids[$];
    int         pool[$];
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    in_is_last = 1'b0;
    hold_req   = 1'b0;
    calm       = 1'b0;
    rst_n      = 1'b0;
    clear_tree();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: known trees, extremes and each corner of the walk.
    for (r = 0; r < PLAN_LEN; r++) begin
      case (PLAN[r].kind)
        ROW_HEAP: begin
          fill_heap(PLAN[r].b, PLAN[r].root);
          send_header();
        end
        ROW_SPARSE: begin
          hdr_buf[0] = PLAN[r].b;
          hdr_buf[1] = PLAN[r].root;
          for (i = 0; i < hsd_pkg::NODE_LIMIT; i++) hdr_buf[2+i] = hsd_pkg::NO_PARENT;
          hdr_buf[2+0]   = node_code(256);
          hdr_buf[2+257] = node_code(256);
          hdr_buf[2+258] = node_code(257);
          send_header();
        end
        default: begin
          put_byte(PLAN[r].b, PLAN[r].last);
          if (PLAN[r].known) begin
            if (fresh.size() != 1) begin
              $error("row %0d result count: expected 1, got %0d", r, fresh.size());
              err_count++;
            end else if (fresh[0].symbol != PLAN[r].sym ||
                         fresh[0].walk_error != PLAN[r].err) begin
              $error("row %0d symbol/walk_error: expected %0d/%0d, got %0d/%0d", r,
                     PLAN[r].sym, PLAN[r].err, fresh[0].symbol, fresh[0].walk_error);
              err_count++;
            end
          end
        end
      endcase
    end
    settle_symbols();

    // Random files. First: a four-leaf tree under a long receiver hold-off.
    // Second: a full tree with no idling and a mid-file drain. Then a mix of
    // random trees, damaged trees, garbage headers and files cut short.
    data_sent    = 0;
    symbols_seen = 0;
    for (file_no = 0; data_sent < 310 || symbols_seen < 48; file_no++) begin
      pick = $urandom_range(99);
      if (file_no < 2 || pick < 75) begin
        if (file_no == 0) leaves = 4;
        else if (file_no == 1) leaves = hsd_pkg::SYMBOL_COUNT;
        else if ($urandom_range(99) < 50) leaves = $urandom_range(16, 2);
        else if ($urandom_range(99) < 60) leaves = $urandom_range(255, 17);
        else leaves = hsd_pkg::SYMBOL_COUNT;
        // random full binary tree over a random leaf set, random inner numbering
        for (i = 1; i <= hsd_pkg::NODE_LIMIT + 1; i++) hdr_buf[i] = hsd_pkg::NO_PARENT;
        leaf_ids.delete();
        inner_ids.delete();
        pool.delete();
        for (k = 0; k < hsd_pkg::SYMBOL_COUNT; k++) leaf_ids.push_back(k);
        for (k = hsd_pkg::SYMBOL_COUNT; k < hsd_pkg::NODE_LIMIT; k++) inner_ids.push_back(k);
        for (k = 0; k < leaves; k++) begin
          j = $urandom_range(leaf_ids.size() - 1);
          pool.push_back(leaf_ids[j]);
          leaf_ids.delete(j);
        end
        for (k = 1; k < leaves; k++) begin
          j = $urandom_range(pool.size() - 1);
          a = pool[j];
          pool.delete(j);
          j = $urandom_range(pool.size() - 1);
          b = pool[j];
          pool.delete(j);
          j = $urandom_range(inner_ids.size() - 1);
          p = inner_ids[j];
          inner_ids.delete(j);
          hdr_buf[2+a] = node_code(p);
          hdr_buf[2+b] = node_code(p);
          pool.push_back(p);
        end
        hdr_buf[1] = node_code(pool[0]);
        // damaged tree: a few header bytes overwritten
        if (file_no >= 2 && pick >= 60)
          repeat ($urandom_range(4, 1))
            hdr_buf[$urandom_range(hsd_pkg::NODE_LIMIT + 1, 1)] = 8'($urandom_range(255));
      end else begin
        for (i = 1; i <= hsd_pkg::NODE_LIMIT + 1; i++)
          hdr_buf[i] = ($urandom_range(99) < 30) ? hsd_pkg::NO_PARENT
                                                 : 8'($urandom_range(255));
      end
      hdr_buf[0] = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 8))
                                             : 8'($urandom_range(7));

      if (file_no >= 2 && $urandom_range(99) < 12) begin
        // file ends somewhere inside its header
        cut = $urandom_range(hsd_pkg::NODE_LIMIT + 1);
        for (i = 0; i <= cut; i++) put_byte(hdr_buf[i], i == cut);
      end else begin
        if (file_no == 1) calm <= 1'b1;
        send_header();
        n_data = (file_no < 2) ? 48 : $urandom_range(60, 8);
        for (d = 0; d < n_data; d++) begin
          if (file_no == 0 && d == 0) hold_req <= 1'b1;
          if (file_no == 1 && d == n_data / 2) settle_symbols();
          put_byte(8'($urandom_range(255)), d == n_data - 1);
          data_sent++;
          symbols_seen += fresh.size();
        end
        calm <= 1'b0;
      end
    end

    // Drain, then leave room for any stray transaction to show up.
    settle_symbols();
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hsd_pkg.sv
hdl/hsd_child_tbl.sv
hdl/hsd_out_stage.sv
hdl/huffman_stream_decoder_top.sv
bench/tb.sv
